/* hw/rtl/srec_pkg.sv */
// Shared types and constants for the S-record line parser.
// Used by the front, back, top level and checker; no dependencies.
package srec_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_4  = 8'h34;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_F  = 8'h46;

    localparam logic [3:0] HEX_A_VAL   = 4'hA;
    localparam logic [7:0] SUM_OK      = 8'hFF;
    localparam logic [3:0] TYPE_BANNED = 4'd4;
    localparam logic [3:0] TYPE_MAX    = 4'd9;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_HEX  = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_COUNT    = 3'd3,
        ST_NOT_REC  = 3'd4
    } t_status;

    // classified character, front -> back
    typedef struct packed {
        logic       eol;
        logic       is_s;
        logic       type_ok;
        logic [3:0] digit;
        logic       hex_ok;
        logic [3:0] hex;
    } t_tok;

    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [3:0]  rtype;
        logic [31:0] address;
        logic [7:0]  data;
        logic [7:0]  index;
    } t_res;

endpackage

/* hw/rtl/srec_fifo.sv */
// Small register queue, generic width and depth.
// No package dependencies.
module srec_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

/* hw/rtl/srec_front.sv */
// Front end: classifies each character (line end, 'S', type digit, hex)
// and queues the token. Depends on srec_pkg and srec_fifo.
module srec_front
    import srec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_file,
    output logic       o_full,
    input  logic       i_tok_rd,
    output t_tok       o_tok,
    output logic       o_tok_valid
);
    t_tok       tok;
    logic       is_dec, is_af;
    logic [7:0] af_off;
    logic       tok_empty;

    always_comb begin
        is_dec       = (i_ch >= CH_0) && (i_ch <= CH_9);
        is_af        = (i_ch >= CH_A) && (i_ch <= CH_F);
        af_off       = i_ch - CH_A;
        tok.eol      = i_end_of_file || (i_ch == CH_NL);
        tok.is_s     = (i_ch == CH_S);
        tok.type_ok  = is_dec && (i_ch != CH_4);
        tok.digit    = i_ch[3:0];
        tok.hex_ok   = is_dec || is_af;
        tok.hex      = is_dec ? i_ch[3:0] : (af_off[3:0] + HEX_A_VAL);
    end

    srec_fifo #(
        .WIDTH ($bits(t_tok)),
        .DEPTH (DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (tok),
        .i_rd    (i_tok_rd),
        .o_rdata (o_tok),
        .o_full  (o_full),
        .o_empty (tok_empty)
    );

    assign o_tok_valid = !tok_empty;

endmodule

/* hw/rtl/srec_back.sv */
// Back end: record parser state machine over classified tokens, plus the
// result queue. Depends on srec_pkg and srec_fifo.
module srec_back
    import srec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    input  logic i_tok_valid,
    output logic o_tok_rd,
    input  logic i_pop,
    output t_res o_res,
    output logic o_empty
);
    typedef enum logic [3:0] {
        PH_WAIT_S, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_CHECKSUM, PH_EOL,
        PH_SKIP_HEX, PH_SKIP_CHK, PH_SKIP_CNT, PH_SKIP_NOTREC
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_type, n_type;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_addr, n_addr;
    logic [3:0]  r_hi, n_hi;
    logic        r_second, n_second;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_pos, n_pos;

    logic        go, res_full, res_wr;
    t_res        res;
    logic [7:0]  b, sum_b, len8, left_dec, data_len;
    logic [2:0]  len;

    assign go       = i_tok_valid && !res_full;
    assign o_tok_rd = go;

    always_comb begin
        case (r_type)
            4'd2, 4'd6, 4'd8: len = 3'd3;
            4'd3, 4'd7:       len = 3'd4;
            default:          len = 3'd2;
        endcase
        len8     = {5'b0, len};
        b        = {r_hi, i_tok.hex};
        sum_b    = r_sum + b;
        left_dec = r_left - 8'd1;
        data_len = r_count - len8 - 8'd1;

        n_phase  = r_phase;
        n_type   = r_type;
        n_count  = r_count;
        n_addr   = r_addr;
        n_hi     = r_hi;
        n_second = r_second;
        n_left   = r_left;
        n_sum    = r_sum;
        n_pos    = r_pos;

        res_wr       = 1'b0;
        res.kind     = KIND_DATA;
        res.status   = ST_OK;
        res.rtype    = r_type;
        res.address  = r_addr;
        res.data     = b;
        res.index    = r_pos;

        if (go) begin
            if (i_tok.eol) begin
                // empty lines close silently
                if (r_phase != PH_WAIT_S) begin
                    res_wr   = 1'b1;
                    res.kind = KIND_STATUS;
                    res.data = 8'd0;
                    case (r_phase)
                        PH_COUNT, PH_ADDR, PH_DATA, PH_CHECKSUM,
                        PH_SKIP_HEX: res.status = ST_BAD_HEX;
                        PH_EOL:      res.status = ST_OK;
                        PH_SKIP_CHK: res.status = ST_CHECKSUM;
                        PH_SKIP_CNT: res.status = ST_COUNT;
                        default:     res.status = ST_NOT_REC;
                    endcase
                end
                n_phase  = PH_WAIT_S;
                n_type   = '0;
                n_count  = '0;
                n_addr   = '0;
                n_hi     = '0;
                n_second = 1'b0;
                n_left   = '0;
                n_sum    = '0;
                n_pos    = '0;
            end else begin
                case (r_phase)
                    PH_WAIT_S: begin
                        n_phase = i_tok.is_s ? PH_TYPE : PH_SKIP_NOTREC;
                    end
                    PH_TYPE: begin
                        if (i_tok.type_ok) begin
                            n_type  = i_tok.digit;
                            n_phase = PH_COUNT;
                        end else begin
                            n_phase = PH_SKIP_NOTREC;
                        end
                    end
                    PH_EOL: begin
                        n_phase = PH_SKIP_CNT;
                    end
                    PH_COUNT, PH_ADDR, PH_DATA, PH_CHECKSUM: begin
                        if (!i_tok.hex_ok) begin
                            n_phase = PH_SKIP_HEX;
                        end else if (!r_second) begin
                            n_hi     = i_tok.hex;
                            n_second = 1'b1;
                        end else begin
                            n_second = 1'b0;
                            n_sum    = sum_b;
                            case (r_phase)
                                PH_COUNT: begin
                                    n_count = b;
                                    if (b < len8 + 8'd1) begin
                                        n_phase = PH_SKIP_CNT;
                                    end else begin
                                        n_left  = len8;
                                        n_phase = PH_ADDR;
                                    end
                                end
                                PH_ADDR: begin
                                    n_addr = {r_addr[23:0], b};
                                    if (left_dec == 8'd0) begin
                                        n_left  = data_len;
                                        n_pos   = 8'd0;
                                        n_phase = (data_len == 8'd0) ? PH_CHECKSUM : PH_DATA;
                                    end else begin
                                        n_left = left_dec;
                                    end
                                end
                                PH_DATA: begin
                                    res_wr = 1'b1;
                                    n_pos  = r_pos + 8'd1;
                                    n_left = left_dec;
                                    if (left_dec == 8'd0) begin
                                        n_phase = PH_CHECKSUM;
                                    end
                                end
                                default: begin
                                    n_phase = (sum_b == SUM_OK) ? PH_EOL : PH_SKIP_CHK;
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_S;
            r_type   <= '0;
            r_count  <= '0;
            r_addr   <= '0;
            r_hi     <= '0;
            r_second <= 1'b0;
            r_left   <= '0;
            r_sum    <= '0;
            r_pos    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_hi     <= n_hi;
            r_second <= n_second;
            r_left   <= n_left;
            r_sum    <= n_sum;
            r_pos    <= n_pos;
        end
    end

    srec_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res),
        .i_rd    (i_pop),
        .o_rdata (o_res),
        .o_full  (res_full),
        .o_empty (o_empty)
    );

endmodule

/* hw/rtl/srec_line_parser_core.sv */
// S-record line parser top level: front classifier, token queue, parser, result queue.
// An accepted character is registered in the token queue; the parser then writes its
// result to the result queue, from which it is popped. Throughput: one character per
// cycle, set by the single-step parser state machine, while the result queue has room.
// Reset: synchronous, active low; empties both queues and returns the parser to line start.
// Depends on srec_pkg, srec_front, srec_back.
module srec_line_parser_core
    import srec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [3:0]  o_record_type,
    output logic [31:0] o_address,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index
);
    t_tok tok;
    logic tok_valid, tok_rd;
    t_res res;

    srec_front #(.DEPTH(DEPTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_ch          (i_ch),
        .i_end_of_file (i_end_of_file),
        .o_full        (full),
        .i_tok_rd      (tok_rd),
        .o_tok         (tok),
        .o_tok_valid   (tok_valid)
    );

    srec_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok),
        .i_tok_valid (tok_valid),
        .o_tok_rd    (tok_rd),
        .i_pop       (pop),
        .o_res       (res),
        .o_empty     (empty)
    );

    assign o_kind        = res.kind;
    assign o_status      = res.status;
    assign o_record_type = res.rtype;
    assign o_address     = res.address;
    assign o_data_byte   = res.data;
    assign o_byte_index  = res.index;

endmodule

/* hw/rtl/srec_chk.sv */
// Port-level checker for srec_line_parser_core, bound to the top level.
// Depends on srec_pkg.
module srec_chk
    import srec_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [2:0]  o_status,
    input logic [3:0]  o_record_type,
    input logic [31:0] o_address,
    input logic [7:0]  o_data_byte,
    input logic [7:0]  o_byte_index
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_address)
                              && $stable(o_data_byte) && $stable(o_byte_index)))
        else $error("waiting result changed before pop");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_DATA) |-> (o_status == ST_OK))
        else $error("data result with nonzero status");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_STATUS) |->
        (o_data_byte == 8'd0 && o_status <= ST_NOT_REC))
        else $error("malformed status result");

    a_ok_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_STATUS && o_status == ST_OK) |->
        (o_record_type != TYPE_BANNED && o_record_type <= TYPE_MAX))
        else $error("good line reported with illegal record type");

endmodule

bind srec_line_parser_core srec_chk u_srec_chk (.*);

/* bench/srec_line_parser_core_test.sv */
// Self-checking bench for srec_line_parser_core: drives S-record text one character per
// request, predicts every data byte and line status, and checks them in order.
// Depends on srec_pkg and the srec_line_parser_core RTL.
module srec_line_parser_core_test;
    import srec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1550;
    localparam int HOLD_AT      = 700;   // receiver stops popping after this many chars
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 1100;  // sender drains the block once here
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 1000000;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] LOWER_CASE = 8'h20;
    localparam logic [4:0] NIB_BAD    = 5'h10;

    typedef enum logic [3:0] {
        PS_WAIT_S,
        PS_TYPE,
        PS_COUNT,
        PS_ADDR,
        PS_DATA,
        PS_CHECKSUM,
        PS_EOL,
        PS_SKIP_HEX,
        PS_SKIP_SUM,
        PS_SKIP_COUNT,
        PS_SKIP_NOTREC
    } t_parse_state;

    typedef struct {
        logic [7:0] ch;
        logic       eof;
        bit         typed;
        bit         typed_has;
        t_res       typed_res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_ch = 8'h00;
    logic        i_end_of_file = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_kind;
    logic [2:0]  o_status;
    logic [3:0]  o_record_type;
    logic [31:0] o_address;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_byte_index;

    srec_line_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_ch          (i_ch),
        .i_end_of_file (i_end_of_file),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_record_type (o_record_type),
        .o_address     (o_address),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser shadow state
    t_parse_state ps;
    logic [3:0]   rec_type;
    logic [7:0]   byte_count;
    logic [31:0]  load_addr;
    logic [3:0]   hi_nib;
    logic         have_hi;
    logic [7:0]   remaining;
    logic [7:0]   line_sum;
    logic [7:0]   data_seen;

    t_res      expected_results[$];
    t_stim_row stim_table[$];

    int  errors = 0;
    int  accepted_items = 0;
    int  data_checked = 0;
    int  status_checked = 0;
    int  cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            return {1'b0, 4'(c - CH_0)};
        end
        if (c >= CH_A && c <= CH_F) begin
            return {1'b0, 4'(c - CH_A) + HEX_A_VAL};
        end
        return NIB_BAD;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < HEX_A_VAL) ? CH_0 + 8'(n) : CH_A + 8'(n - HEX_A_VAL);
    endfunction

    function automatic logic [2:0] addr_bytes(input logic [3:0] t);
        case (t)
            4'd2, 4'd6, 4'd8: return 3'd3;
            4'd3, 4'd7:       return 3'd4;
            default:          return 3'd2;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_line();
        ps         = PS_WAIT_S;
        rec_type   = '0;
        byte_count = '0;
        load_addr  = '0;
        hi_nib     = '0;
        have_hi    = 1'b0;
        remaining  = '0;
        line_sum   = '0;
        data_seen  = '0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic e,
                              output bit produced, output t_res r);
        logic [4:0] nib;
        logic [7:0] b;
        logic [2:0] alen;
        produced = 1'b0;
        r = '0;
        if (e || c == CH_NL) begin
            if (ps != PS_WAIT_S) begin
                produced  = 1'b1;
                r.kind    = KIND_STATUS;
                case (ps)
                    PS_COUNT, PS_ADDR, PS_DATA, PS_CHECKSUM,
                    PS_SKIP_HEX:   r.status = ST_BAD_HEX;
                    PS_EOL:        r.status = ST_OK;
                    PS_SKIP_SUM:   r.status = ST_CHECKSUM;
                    PS_SKIP_COUNT: r.status = ST_COUNT;
                    default:       r.status = ST_NOT_REC;
                endcase
                r.rtype   = rec_type;
                r.address = load_addr;
                r.index   = data_seen;
            end
            clear_line();
            return;
        end
        case (ps)
            PS_WAIT_S: ps = (c == CH_S) ? PS_TYPE : PS_SKIP_NOTREC;
            PS_TYPE: begin
                if (c >= CH_0 && c <= CH_9 && c != CH_4) begin
                    rec_type = 4'(c - CH_0);
                    ps = PS_COUNT;
                end else begin
                    ps = PS_SKIP_NOTREC;
                end
            end
            PS_EOL: ps = PS_SKIP_COUNT;
            PS_COUNT, PS_ADDR, PS_DATA, PS_CHECKSUM: begin
                nib = hex_nibble(c);
                if (nib[4]) begin
                    ps = PS_SKIP_HEX;
                end else if (!have_hi) begin
                    hi_nib  = nib[3:0];
                    have_hi = 1'b1;
                end else begin
                    have_hi  = 1'b0;
                    b        = {hi_nib, nib[3:0]};
                    line_sum = line_sum + b;
                    alen     = addr_bytes(rec_type);
                    case (ps)
                        PS_COUNT: begin
                            byte_count = b;
                            if (int'(b) < int'(alen) + 1) begin
                                ps = PS_SKIP_COUNT;
                            end else begin
                                remaining = 8'(alen);
                                ps = PS_ADDR;
                            end
                        end
                        PS_ADDR: begin
                            load_addr = {load_addr[23:0], b};
                            remaining = remaining - 8'd1;
                            if (remaining == 8'd0) begin
                                remaining = byte_count - 8'(alen) - 8'd1;
                                data_seen = '0;
                                ps = (remaining == 8'd0) ? PS_CHECKSUM : PS_DATA;
                            end
                        end
                        PS_DATA: begin
                            produced  = 1'b1;
                            r.kind    = KIND_DATA;
                            r.status  = ST_OK;
                            r.rtype   = rec_type;
                            r.address = load_addr;
                            r.data    = b;
                            r.index   = data_seen;
                            data_seen = data_seen + 8'd1;
                            remaining = remaining - 8'd1;
                            if (remaining == 8'd0) ps = PS_CHECKSUM;
                        end
                        default: ps = (line_sum == SUM_OK) ? PS_EOL : PS_SKIP_SUM;
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    // Offer one character and hold it until the block takes it.
    task automatic send_char(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input t_res typed_res = '0);
        int   gap;
        bit   produced;
        t_res r;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_ch          <= c;
        i_end_of_file <= e;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        accepted_items++;
        if (accepted_items % 64 == 0) tx_calm = ($urandom_range(3) == 0);
        parse_char(c, e, produced, r);
        if (typed) begin
            if (typed_has) expected_results.push_back(typed_res);
        end else if (produced) begin
            expected_results.push_back(r);
        end
    endtask

    task automatic add_row(input logic [7:0] c, input logic e, input bit typed,
                           input bit typed_has, input t_status st, input logic [3:0] rt);
        t_stim_row row;
        row.ch        = c;
        row.eof       = e;
        row.typed     = typed;
        row.typed_has = typed_has;
        row.typed_res = '0;
        row.typed_res.kind   = KIND_STATUS;
        row.typed_res.status = st;
        row.typed_res.rtype  = rt;
        stim_table.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, 1'b0, ST_OK, 4'd0);
    endtask

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        logic [4:0] nib;
        if ($urandom_range(1) == 0) return CH_A + LOWER_CASE + 8'($urandom_range(5));
        do begin
            c   = 8'($urandom_range(255));
            nib = hex_nibble(c);
        end while (!nib[4] || c == CH_NL);
        return c;
    endfunction

    task automatic send_random_line();
        logic [7:0] txt[$];
        logic [7:0] body[$];
        logic [7:0] c;
        logic [7:0] sum;
        logic [3:0] t;
        logic [2:0] alen;
        int         sel, fault, dlen, amode, p, n;
        sel = $urandom_range(99);
        if (sel < 8) begin
            // noise: random bytes, possibly empty or containing newlines
            n = $urandom_range(12);
            repeat (n) txt.push_back(8'($urandom_range(255)));
        end else begin
            p     = $urandom_range(8);
            t     = (p < 4) ? 4'(p) : 4'(p + 1);
            alen  = addr_bytes(t);
            dlen  = ($urandom_range(39) == 0) ? $urandom_range(9, 254 - alen)
                                               : $urandom_range(0, 8);
            fault = $urandom_range(99);
            amode = $urandom_range(3);
            body.push_back(8'(dlen + alen + 1));
            if (fault >= 92 && fault < 96) body[0] = 8'($urandom_range(alen));
            for (int i = 0; i < alen; i++) begin
                body.push_back(amode == 0 ? 8'h00 : amode == 1 ? 8'hFF
                                          : 8'($urandom_range(255)));
            end
            repeat (dlen) body.push_back(8'($urandom_range(255)));
            sum = '0;
            foreach (body[i]) sum = sum + body[i];
            body.push_back(SUM_OK - sum);
            txt.push_back(CH_S);
            txt.push_back(CH_0 + 8'(t));
            foreach (body[i]) begin
                txt.push_back(hex_char(body[i][7:4]));
                txt.push_back(hex_char(body[i][3:0]));
            end
            if (fault >= 70 && fault < 76) begin
                c = body[body.size() - 1];
                txt[txt.size() - 1] = hex_char(c[3:0] ^ 4'($urandom_range(1, 15)));
            end else if (fault >= 76 && fault < 82) begin
                txt[$urandom_range(2, txt.size() - 1)] = bad_char();
            end else if (fault >= 82 && fault < 87) begin
                n = $urandom_range(1, txt.size() - 1);
                while (txt.size() > n) void'(txt.pop_back());
            end else if (fault >= 87 && fault < 92) begin
                if ($urandom_range(1) == 0) begin
                    txt.push_back(CH_CR);
                end else begin
                    do c = 8'($urandom_range(255)); while (c == CH_NL);
                    txt.push_back(c);
                end
            end else if (fault >= 96) begin
                if ($urandom_range(1) == 0) begin
                    txt[1] = CH_4;
                end else begin
                    do c = 8'($urandom_range(255)); while (c == CH_NL);
                    txt[1] = c;
                end
            end
        end
        foreach (txt[i]) send_char(txt[i], 1'b0);
        if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), 1'b1);
        else send_char(CH_NL, 1'b0);
    endtask

    // receiver: random pop gaps, one long hold-off once the run is well under way
    initial begin
        int idle_left;
        int calm_timer;
        bit held;
        idle_left  = 0;
        calm_timer = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (++calm_timer == 150) begin
                calm_timer = 0;
                rx_calm    = ($urandom_range(3) == 0);
            end
            if (idle_left == 0) begin
                if (!held && accepted_items >= HOLD_AT) begin
                    idle_left = HOLD_CYCLES;
                    held      = 1'b1;
                end else if (!rx_calm && $urandom_range(3) == 0) begin
                    idle_left = pick_gap();
                end
            end
            pop <= (idle_left == 0);
            if (idle_left > 0) idle_left--;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0b status %0d",
                         $time, o_kind, o_status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("record_type", 32'(want.rtype), 32'(o_record_type));
                check_field("address", want.address, o_address);
                check_field("data_byte", 32'(want.data), 32'(o_data_byte));
                check_field("byte_index", 32'(want.index), 32'(o_byte_index));
                if (want.kind == KIND_DATA) data_checked++;
                else status_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("FAIL srec_line_parser_core");
            $finish;
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;
        clear_line();

        // empty line, bare non-record closed by end of file, banned type, lower-case hex,
        // count below address length plus one, bad checksum
        add_row(CH_NL, 1'b0, 1'b1, 1'b0, ST_OK, 4'd0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK, 4'd0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b1, ST_NOT_REC, 4'd0);
        add_text("S4");
        add_row(CH_NL, 1'b0, 1'b1, 1'b1, ST_NOT_REC, 4'd0);
        add_text("S1a");
        add_row(CH_NL, 1'b0, 1'b1, 1'b1, ST_BAD_HEX, 4'd1);
        add_text("S102");
        add_row(CH_NL, 1'b0, 1'b1, 1'b1, ST_COUNT, 4'd1);
        add_text("S9030000FB");
        add_row(CH_NL, 1'b0, 1'b1, 1'b1, ST_CHECKSUM, 4'd9);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            send_char(stim_table[i].ch, stim_table[i].eof, stim_table[i].typed,
                      stim_table[i].typed_has, stim_table[i].typed_res);
        end
        while (accepted_items < ITEM_TARGET) begin
            if (!paused && accepted_items >= PAUSE_AT) begin
                push <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
                paused = 1'b1;
            end
            send_random_line();
        end
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters over %0d cycles.", accepted_items, cycles);
        $display("Checked %0d data bytes and %0d line statuses, %0d errors.",
                 data_checked, status_checked, errors);
        if (errors == 0) begin
            $display("PASS srec_line_parser_core");
        end else begin
            $display("FAIL srec_line_parser_core");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/srec_pkg.sv
hw/rtl/srec_fifo.sv
hw/rtl/srec_front.sv
hw/rtl/srec_back.sv
hw/rtl/srec_line_parser_core.sv
hw/rtl/srec_chk.sv
bench/srec_line_parser_core_test.sv
